// ===== rtl/icf_pkg.sv =====
// Shared types, constants and tables for the IMU complementary filter.
// No dependencies; every file but icf_ifs refers to it by scoped names.
package icf_pkg;

   localparam int ROOT_STEPS   = 24;
   localparam int CORDIC_STEPS = 16;
   localparam int CNT_W        = 5;
   localparam int IDX_W        = $clog2(CORDIC_STEPS);

   localparam logic [1:0] CSR_OFF_X = 2'd0;
   localparam logic [1:0] CSR_OFF_Y = 2'd1;
   localparam logic [1:0] CSR_OFF_Z = 2'd2;

   localparam logic [1:0] BL_RATE = 2'd0;
   localparam logic [1:0] BL_DT   = 2'd1;
   localparam logic [1:0] BL_SUM  = 2'd2;
   localparam logic [1:0] BL_MIX  = 2'd3;

   localparam logic [7:0]  GYRO_DIV = 8'd131;
   localparam logic [23:0] GYRO_RND = 24'd65;
   // ceil(2^32 / 131); the quotient taken from bits 32 and up is exact for
   // dividends below 2^28.
   localparam logic [24:0] RECIP_131 = 25'd32786010;
   localparam logic signed [14:0] DT_Q    = 15'sd8389;
   localparam logic signed [20:0] ALPHA_Q = 21'sd1027604;
   localparam logic signed [15:0] BETA_Q  = 16'sd20972;
   localparam logic signed [31:0] DEG90   = 32'sd5898240;

   typedef logic signed [27:0] vec_type;
   typedef logic signed [31:0] ang_type;

   typedef struct packed {
      logic             capture;
      logic             root_step;
      logic             angle_load;
      logic             angle_step;
      logic [IDX_W-1:0] angle_idx;
      logic             blend_en;
      logic [1:0]       blend_sel;
      logic             commit;
   } cmd_type;

   typedef struct packed {
      logic out_full;
   } stat_type;

   // atan(2^-i) in degrees, Q16.
   function automatic ang_type atan_q16(input logic [IDX_W-1:0] i);
      ang_type r;
      case (i)
         4'd0:    r = 32'sd2949120;
         4'd1:    r = 32'sd1740967;
         4'd2:    r = 32'sd919879;
         4'd3:    r = 32'sd466945;
         4'd4:    r = 32'sd234379;
         4'd5:    r = 32'sd117304;
         4'd6:    r = 32'sd58666;
         4'd7:    r = 32'sd29335;
         4'd8:    r = 32'sd14668;
         4'd9:    r = 32'sd7334;
         4'd10:   r = 32'sd3667;
         4'd11:   r = 32'sd1833;
         4'd12:   r = 32'sd917;
         4'd13:   r = 32'sd458;
         4'd14:   r = 32'sd229;
         4'd15:   r = 32'sd115;
         default: r = 32'sd0;
      endcase
      return r;
   endfunction

   // Clamp a wide signed value to signed 32 bits.
   function automatic logic [31:0] sat32(input logic signed [39:0] v);
      logic [31:0] r;
      if (v > 40'sd2147483647) begin
         r = 32'h7FFF_FFFF;
      end else if (v < -40'sd2147483648) begin
         r = 32'h8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

// ===== rtl/icf_ifs.sv =====
// Channel interfaces of the IMU complementary filter: request, response, CSR write.
// Depends on nothing.
interface icf_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] accel_x;
   logic signed [15:0] accel_y;
   logic signed [15:0] accel_z;
   logic signed [15:0] gyro_x;
   logic signed [15:0] gyro_y;
   logic signed [15:0] gyro_z;
   logic               in_last;
   modport source (output valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
                   in_last, input ready);
   modport sink (input valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
                 in_last, output ready);
endinterface

interface icf_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] roll_angle;
   logic signed [31:0] pitch_angle;
   logic signed [31:0] yaw_dps;
   logic               out_last;
   modport source (output valid, roll_angle, pitch_angle, yaw_dps, out_last, input ready);
   modport sink (input valid, roll_angle, pitch_angle, yaw_dps, out_last, output ready);
endinterface

interface icf_csr_if;
   logic               valid;
   logic               ready;
   logic [1:0]         index;
   logic signed [24:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/icf_ctrl.sv =====
// Sequencer of the IMU complementary filter: steps the datapath through
// root, angle and blend phases to the commit. Depends on icf_pkg.
module icf_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  icf_pkg::stat_type stat,
   output icf_pkg::cmd_type  cmd
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_ROOT   = 3'd1;
   localparam logic [2:0] S_LOAD   = 3'd2;
   localparam logic [2:0] S_ANGLE  = 3'd3;
   localparam logic [2:0] S_BLEND  = 3'd4;
   localparam logic [2:0] S_COMMIT = 3'd5;

   logic [2:0]                 state_ff, state_in;
   logic [icf_pkg::CNT_W-1:0]  cnt_ff, cnt_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff + 1'b1;
      cmd      = '0;
      cmd.angle_idx = cnt_ff[icf_pkg::IDX_W-1:0];
      cmd.blend_sel = cnt_ff[1:0];
      case (state_ff)
         S_IDLE: begin
            cnt_in = '0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_ROOT;
            end
         end
         S_ROOT: begin
            cmd.root_step = 1'b1;
            if (cnt_ff == icf_pkg::CNT_W'(icf_pkg::ROOT_STEPS - 1)) begin
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            cmd.angle_load = 1'b1;
            cnt_in         = '0;
            state_in       = S_ANGLE;
         end
         S_ANGLE: begin
            cmd.angle_step = 1'b1;
            if (cnt_ff == icf_pkg::CNT_W'(icf_pkg::CORDIC_STEPS - 1)) begin
               cnt_in   = '0;
               state_in = S_BLEND;
            end
         end
         S_BLEND: begin
            cmd.blend_en = 1'b1;
            if (cnt_ff[1:0] == icf_pkg::BL_MIX) begin
               state_in = S_COMMIT;
            end
         end
         S_COMMIT: begin
            if (!stat.out_full) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

// ===== rtl/icf_dp.sv =====
// Datapath of the IMU complementary filter: gyro scaling, square root, two CORDIC
// lanes, blend pipeline, estimates, offsets and the response register. Depends on icf_pkg.
module icf_dp (
   input  logic               clock,
   input  logic               reset,
   input  icf_pkg::cmd_type   cmd,
   output icf_pkg::stat_type  stat,
   input  logic signed [15:0] accel_x,
   input  logic signed [15:0] accel_y,
   input  logic signed [15:0] accel_z,
   input  logic signed [15:0] gyro_x,
   input  logic signed [15:0] gyro_y,
   input  logic signed [15:0] gyro_z,
   input  logic               in_last,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic signed [24:0] csr_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] roll_angle,
   output logic signed [31:0] pitch_angle,
   output logic signed [31:0] yaw_dps,
   output logic               out_last
);

   logic signed [15:0] ax_ff, ay_ff, az_ff;
   logic               last_ff;
   logic signed [24:0] off_ff [3];

   // Gyro scaling by 1/131 with rounding, by reciprocal multiplication. The
   // magnitude times 2^16 is split so that the quotient of the magnitude and the
   // remainder carried into the low half each stay in the exact range of the
   // reciprocal. The three registered steps settle well before the blend.
   logic [15:0] gmag_ff [3], gmag_in [3];
   logic [7:0]  q0_ff [3], q0_in [3];
   logic [7:0]  r0_ff [3], r0_in [3];
   logic [24:0] quo_ff [3], quo_in [3];
   logic        neg_ff [3];
   logic signed [15:0] graw [3];

   // Square root of (ay^2 + az^2) * 2^16.
   logic [47:0] sq_n_ff, sq_res_ff, sq_bit_ff;
   logic [47:0] sq_n_in, sq_res_in, sq_sum;
   logic [31:0] sq_acc;

   // CORDIC lanes: lane 0 roll, lane 1 pitch.
   icf_pkg::vec_type x_ff [2], y_ff [2], x_in [2], y_in [2], x0 [2], y0 [2];
   icf_pkg::ang_type z_ff [2], z_in [2];
   logic             zero_ff [2];
   icf_pkg::ang_type step_a;

   // Blend pipeline.
   logic signed [25:0] g_ff  [3];
   logic signed [40:0] p_ff  [2];
   logic signed [32:0] t_ff  [2];
   logic signed [53:0] pa_ff [2];
   logic signed [47:0] pb_ff [2];
   logic signed [31:0] est_ff [2];
   logic signed [54:0] mix [2];
   logic signed [40:0] pr [2];
   icf_pkg::ang_type   acc [2];

   logic               out_valid_ff;
   logic signed [31:0] roll_ff, pitch_ff, yaw_ff;
   logic               olast_ff;

   assign graw[0] = gyro_x;
   assign graw[1] = gyro_y;
   assign graw[2] = gyro_z;

   always_comb begin
      logic [16:0] mag;
      logic [40:0] p0;
      logic [15:0] back;
      logic [23:0] n1;
      logic [48:0] p1;
      for (int k = 0; k < 3; k++) begin
         mag        = graw[k][15] ? -{graw[k][15], graw[k]} : {graw[k][15], graw[k]};
         gmag_in[k] = mag[15:0];
         p0         = 41'(gmag_ff[k]) * 41'(icf_pkg::RECIP_131);
         q0_in[k]   = p0[39:32];
         back       = 16'(q0_ff[k]) * 16'(icf_pkg::GYRO_DIV);
         r0_in[k]   = 8'(gmag_ff[k] - back);
         n1         = {r0_ff[k], 16'b0} + icf_pkg::GYRO_RND;
         p1         = 49'(n1) * 49'(icf_pkg::RECIP_131);
         quo_in[k]  = {1'b0, q0_ff[k], 16'b0} + 25'(p1[48:32]);
      end
   end

   always_comb begin
      logic signed [31:0] sy, sz;
      sy        = accel_y * accel_y;
      sz        = accel_z * accel_z;
      sq_acc    = 32'(sy) + 32'(sz);
      sq_sum    = sq_res_ff + sq_bit_ff;
      sq_n_in   = sq_n_ff;
      sq_res_in = sq_res_ff;
      if (sq_n_ff >= sq_sum) begin
         sq_n_in   = sq_n_ff - sq_sum;
         sq_res_in = (sq_res_ff >> 1) + sq_bit_ff;
      end else begin
         sq_res_in = sq_res_ff >> 1;
      end
   end

   always_comb begin
      x0[0] = icf_pkg::vec_type'(sq_res_ff[23:0]);
      y0[0] = -(icf_pkg::vec_type'(ax_ff) <<< 8);
      x0[1] = icf_pkg::vec_type'(az_ff) <<< 8;
      y0[1] = icf_pkg::vec_type'(ay_ff) <<< 8;
      step_a = icf_pkg::atan_q16(cmd.angle_idx);
      for (int k = 0; k < 2; k++) begin
         x_in[k] = x_ff[k];
         y_in[k] = y_ff[k];
         z_in[k] = z_ff[k];
         if (cmd.angle_load) begin
            x_in[k] = x0[k];
            y_in[k] = y0[k];
            z_in[k] = '0;
            if (x0[k] < 0) begin
               if (y0[k] >= 0) begin
                  x_in[k] = y0[k];
                  y_in[k] = -x0[k];
                  z_in[k] = icf_pkg::DEG90;
               end else begin
                  x_in[k] = -y0[k];
                  y_in[k] = x0[k];
                  z_in[k] = -icf_pkg::DEG90;
               end
            end
         end else if (cmd.angle_step) begin
            if (y_ff[k] > 0) begin
               x_in[k] = x_ff[k] + (y_ff[k] >>> cmd.angle_idx);
               y_in[k] = y_ff[k] - (x_ff[k] >>> cmd.angle_idx);
               z_in[k] = z_ff[k] + step_a;
            end else begin
               x_in[k] = x_ff[k] - (y_ff[k] >>> cmd.angle_idx);
               y_in[k] = y_ff[k] + (x_ff[k] >>> cmd.angle_idx);
               z_in[k] = z_ff[k] - step_a;
            end
         end
      end
   end

   always_comb begin
      for (int k = 0; k < 2; k++) begin
         acc[k] = zero_ff[k] ? '0 : z_ff[k];
         pr[k]  = p_ff[k] + 41'sd524288;
         mix[k] = pa_ff[k] + 55'(pb_ff[k]) + 55'sd524288;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         ax_ff   <= accel_x;
         ay_ff   <= accel_y;
         az_ff   <= accel_z;
         last_ff <= in_last;
         for (int k = 0; k < 3; k++) begin
            neg_ff[k]  <= graw[k][15];
            gmag_ff[k] <= gmag_in[k];
         end
         sq_n_ff   <= {sq_acc, 16'b0};
         sq_res_ff <= '0;
         sq_bit_ff <= 48'h4000_0000_0000;
      end else if (cmd.root_step) begin
         sq_n_ff   <= sq_n_in;
         sq_res_ff <= sq_res_in;
         sq_bit_ff <= sq_bit_ff >> 2;
      end
      for (int k = 0; k < 3; k++) begin
         q0_ff[k]  <= q0_in[k];
         r0_ff[k]  <= r0_in[k];
         quo_ff[k] <= quo_in[k];
      end
      for (int k = 0; k < 2; k++) begin
         x_ff[k] <= x_in[k];
         y_ff[k] <= y_in[k];
         z_ff[k] <= z_in[k];
         if (cmd.angle_load) begin
            zero_ff[k] <= (x0[k] == '0) && (y0[k] == '0);
         end
      end
      if (cmd.blend_en) begin
         case (cmd.blend_sel)
            icf_pkg::BL_RATE: begin
               for (int k = 0; k < 3; k++) begin
                  g_ff[k] <= (neg_ff[k] ? -$signed({1'b0, quo_ff[k]})
                                        : $signed({1'b0, quo_ff[k]}))
                             - 26'(off_ff[k]);
               end
            end
            icf_pkg::BL_DT: begin
               for (int k = 0; k < 2; k++) begin
                  p_ff[k] <= 41'(g_ff[k]) * 41'(icf_pkg::DT_Q);
               end
            end
            icf_pkg::BL_SUM: begin
               for (int k = 0; k < 2; k++) begin
                  t_ff[k] <= 33'(est_ff[k]) + 33'(pr[k] >>> 20);
               end
            end
            icf_pkg::BL_MIX: begin
               for (int k = 0; k < 2; k++) begin
                  pa_ff[k] <= 54'(t_ff[k]) * 54'(icf_pkg::ALPHA_Q);
                  pb_ff[k] <= 48'(acc[k]) * 48'(icf_pkg::BETA_Q);
               end
            end
            default: begin
            end
         endcase
      end
      if (cmd.commit) begin
         roll_ff  <= icf_pkg::sat32(40'(mix[0] >>> 20));
         pitch_ff <= icf_pkg::sat32(40'(mix[1] >>> 20));
         yaw_ff   <= icf_pkg::sat32(40'(g_ff[2]));
         olast_ff <= last_ff;
      end
      if (reset) begin
         est_ff[0]    <= '0;
         est_ff[1]    <= '0;
         out_valid_ff <= 1'b0;
         for (int k = 0; k < 3; k++) begin
            off_ff[k] <= '0;
         end
      end else begin
         if (cmd.commit) begin
            est_ff[0]    <= icf_pkg::sat32(40'(mix[0] >>> 20));
            est_ff[1]    <= icf_pkg::sat32(40'(mix[1] >>> 20));
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
         if (csr_we) begin
            case (csr_index)
               icf_pkg::CSR_OFF_X: off_ff[0] <= csr_data;
               icf_pkg::CSR_OFF_Y: off_ff[1] <= csr_data;
               icf_pkg::CSR_OFF_Z: off_ff[2] <= csr_data;
               default: begin
               end
            endcase
         end
      end
   end

   assign stat.out_full = out_valid_ff;
   assign rsp_valid     = out_valid_ff;
   assign roll_angle    = roll_ff;
   assign pitch_angle   = pitch_ff;
   assign yaw_dps       = yaw_ff;
   assign out_last      = olast_ff;

endmodule

// ===== rtl/imu_complementary_filter_top.sv =====
// Top level of the IMU complementary filter: wires the sequencer to the datapath
// and the channel interfaces. Depends on icf_pkg, icf_ifs, icf_ctrl and icf_dp.
//
//   channel   | dir | carries
//   ----------+-----+---------------------------------------------------------
//   req_bus   | in  | one IMU sample: three accel axes, three gyro axes, last
//   rsp_bus   | out | roll, pitch (filtered, Q16.16), yaw rate (Q16.16), last
//   csr_bus   | in  | gyro bias writes, index 0..2 for x, y, z
//
// Each request passes from acceptance to the response register through 24
// square-root steps (the gyro scaling settles alongside), one CORDIC load, 16 CORDIC
// steps, four blend stages and one commit. The sequencer then returns to idle and
// accepts the next request only there. The square root gates the start of the roll
// CORDIC lane, and the CORDIC iterations make up most of the rest of the sequence.
// Reset is synchronous and clears the estimates, the biases and the sequencer.
// A response waiting on rsp_bus does not block the next request; the commit of
// that next request waits only until the held response has been taken.
// CSR writes are taken in every cycle.
module imu_complementary_filter_top (
   input  logic      clock,
   input  logic      reset,
   icf_req_if.sink   req_bus,
   icf_rsp_if.source rsp_bus,
   icf_csr_if.sink   csr_bus
);

   icf_pkg::cmd_type  cmd;
   icf_pkg::stat_type stat;

   // The bias registers can always accept a write.
   assign csr_bus.ready = 1'b1;

   icf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   icf_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .accel_x     (req_bus.accel_x),
      .accel_y     (req_bus.accel_y),
      .accel_z     (req_bus.accel_z),
      .gyro_x      (req_bus.gyro_x),
      .gyro_y      (req_bus.gyro_y),
      .gyro_z      (req_bus.gyro_z),
      .in_last     (req_bus.in_last),
      .csr_we      (csr_bus.valid),
      .csr_index   (csr_bus.index),
      .csr_data    (csr_bus.data),
      .rsp_valid   (rsp_bus.valid),
      .rsp_ready   (rsp_bus.ready),
      .roll_angle  (rsp_bus.roll_angle),
      .pitch_angle (rsp_bus.pitch_angle),
      .yaw_dps     (rsp_bus.yaw_dps),
      .out_last    (rsp_bus.out_last)
   );

   // The commit never overwrites a response that has not been taken.
   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> !stat.out_full)
      else $error("commit while response register full");

   // Only one request is in flight: acceptance closes the request channel.
   a_one_inflight: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> !req_bus.ready)
      else $error("request accepted while another is in flight");

   // A response appears only in the cycle after a commit.
   a_rsp_from_commit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_bus.valid) |-> $past(cmd.commit))
      else $error("response raised without a commit");

endmodule

// ===== test/imu_complementary_filter_top_test.sv =====
// Self-checking testbench for imu_complementary_filter_top: random and directed IMU samples.
// It depends on icf_pkg and the channel interfaces in icf_ifs, and it predicts every response.
`timescale 1ns / 1ps

module imu_complementary_filter_top_test;

   localparam int      LATENCY   = 60;
   localparam int      HOLD_LEN  = 400;
   localparam int      WATCHDOG  = 5000;
   localparam int      MAX_SHOWN = 10;
   localparam longint  ALPHA     = 1027604;
   localparam longint  BETA      = 20972;
   localparam longint  DT        = 8389;
   localparam longint  HALF_MIX  = 524288;
   localparam logic [1:0] CSR_UNUSED = 2'd3;

   // The arctangent table, atan(2^-i) in degrees as Q8.24.
   localparam longint ATAN_Q24 [16] = '{
      754974720, 445687602, 235489088, 119537938, 60000934, 30029717, 15018523, 7509720,
      3754917, 1877466, 938734, 469367, 234684, 117342, 58671, 29335};

   typedef struct {
      logic signed [15:0] ax, ay, az, gx, gy, gz;
      logic               last;
   } sample_type;

   typedef struct {
      logic [31:0] roll, pitch, yaw;
      logic        last;
   } attitude_type;

   logic clock;
   logic reset;

   icf_req_if req_bus ();
   icf_rsp_if rsp_bus ();
   icf_csr_if csr_bus ();

   imu_complementary_filter_top uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // Predictor state: the biases as written and the two running estimates.
   longint bias_x, bias_y, bias_z;
   longint roll_track, pitch_track;

   attitude_type pending_attitudes [$];
   int  mismatches;
   int  responses_seen;
   int  samples_sent;
   int  bias_writes;
   int  idle_cycles;
   bit  quiet;
   bit  hold_off;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic longint round_shift(longint v, int s);
      return (s == 0) ? v : ((v + (longint'(1) <<< (s - 1))) >>> s);
   endfunction

   function automatic longint clamp32(longint v);
      if (v > 64'sd2147483647) begin
         return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
         return -64'sd2147483648;
      end
      return v;
   endfunction

   // Counts to deg/s in Q16, rounded half away from zero.
   function automatic longint gyro_dps(logic signed [15:0] raw);
      longint num, mag, q;
      num = longint'(raw) * 65536;
      mag = (num < 0) ? -num : num;
      q   = (mag + 65) / 131;
      return (num < 0) ? -q : q;
   endfunction

   function automatic longint root48(longint unsigned n);
      longint unsigned res, bitv;
      res  = 0;
      bitv = 64'd1 << 46;
      for (int k = 0; k < 24; k++) begin
         if (n >= res + bitv) begin
            n   = n - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return longint'(res);
   endfunction

   // Vectoring CORDIC in degrees, Q16. A vector in the left half plane is turned
   // by a quarter turn first so that the result covers the full circle.
   function automatic longint vector_angle(longint y, longint x);
      longint z, t, dx, dy;
      z = 0;
      if (x == 0 && y == 0) begin
         return 0;
      end
      if (x < 0) begin
         if (y >= 0) begin
            t = x; x = y; y = -t;
            z = 90 * 65536;
         end else begin
            t = x; x = -y; y = t;
            z = -90 * 65536;
         end
      end
      for (int i = 0; i < 16; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y > 0) begin
            x = x + dx; y = y - dy; z = z + round_shift(ATAN_Q24[i], 8);
         end else begin
            x = x - dx; y = y + dy; z = z - round_shift(ATAN_Q24[i], 8);
         end
      end
      return z;
   endfunction

   function automatic longint mix_estimate(longint est, longint rate, longint acc);
      longint t, m;
      t = est + ((rate * DT + HALF_MIX) >>> 20);
      m = ALPHA * t + BETA * acc + HALF_MIX;
      return clamp32(m >>> 20);
   endfunction

   function automatic attitude_type predict_attitude(sample_type s);
      attitude_type a;
      longint ry, rz, mag, rate_x, rate_y, rate_z, yaw;
      ry = longint'(s.ay);
      rz = longint'(s.az);
      mag = root48(longint'(ry * ry + rz * rz) <<< 16);
      rate_x = gyro_dps(s.gx) - bias_x;
      rate_y = gyro_dps(s.gy) - bias_y;
      rate_z = gyro_dps(s.gz) - bias_z;
      roll_track  = mix_estimate(roll_track, rate_x,
                                 vector_angle(-(longint'(s.ax) * 256), mag));
      pitch_track = mix_estimate(pitch_track, rate_y, vector_angle(ry * 256, rz * 256));
      yaw = clamp32(rate_z);
      a.roll  = roll_track[31:0];
      a.pitch = pitch_track[31:0];
      a.yaw   = yaw[31:0];
      a.last  = s.last;
      return a;
   endfunction

   // Offer one sample and hold it until it is taken; then an optional gap.
   task automatic send_sample(sample_type s, int gap);
      req_bus.valid   <= 1'b1;
      req_bus.accel_x <= s.ax;
      req_bus.accel_y <= s.ay;
      req_bus.accel_z <= s.az;
      req_bus.gyro_x  <= s.gx;
      req_bus.gyro_y  <= s.gy;
      req_bus.gyro_z  <= s.gz;
      req_bus.in_last <= s.last;
      do @(posedge clock); while (!req_bus.ready);
      pending_attitudes.push_back(predict_attitude(s));
      samples_sent++;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic sample_type random_sample();
      sample_type s;
      s.ax = 16'($urandom); s.ay = 16'($urandom); s.az = 16'($urandom);
      s.gx = 16'($urandom); s.gy = 16'($urandom); s.gz = 16'($urandom);
      s.last = 1'($urandom_range(0, 1));
      return s;
   endfunction

   // A plausible sample: each accel axis within +-16384 and modest rates.
   function automatic sample_type level_sample();
      sample_type s;
      s.ax = 16'($signed($urandom_range(0, 32768)) - 16384);
      s.ay = 16'($signed($urandom_range(0, 32768)) - 16384);
      s.az = 16'($signed($urandom_range(0, 32768)) - 16384);
      s.gx = 16'($signed($urandom_range(0, 8000)) - 4000);
      s.gy = 16'($signed($urandom_range(0, 8000)) - 4000);
      s.gz = 16'($signed($urandom_range(0, 8000)) - 4000);
      s.last = ($urandom_range(0, 15) == 0);
      return s;
   endfunction

   function automatic int random_gap();
      if (quiet || $urandom_range(0, 3) != 0) begin
         return 0;
      end
      return $urandom_range(1, 10);
   endfunction

   // Bias writes happen only with the pipeline drained, so the request channel
   // is released first and nothing is offered until the write is done.
   task automatic write_bias(logic [1:0] index, logic signed [24:0] value);
      req_bus.valid <= 1'b0;
      wait (pending_attitudes.size() == 0);
      repeat (LATENCY) @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= index;
      csr_bus.data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      case (index)
         icf_pkg::CSR_OFF_X: bias_x = longint'(value);
         icf_pkg::CSR_OFF_Y: bias_y = longint'(value);
         icf_pkg::CSR_OFF_Z: bias_z = longint'(value);
         default: ;
      endcase
      bias_writes++;
   endtask

   task automatic make_sample(output sample_type s, input int ax, ay, az, gx, gy, gz,
                              input int last);
      s.ax = 16'(ax); s.ay = 16'(ay); s.az = 16'(az);
      s.gx = 16'(gx); s.gy = 16'(gy); s.gz = 16'(gz);
      s.last = (last != 0);
   endtask

   // Field extremes, the zero vector, both left-half-plane quadrants and the
   // end marker in both states.
   task automatic test_directed();
      sample_type s;
      make_sample(s, 0, 0, 0, 0, 0, 0, 0);                          send_sample(s, 0);
      make_sample(s, 32767, 32767, 32767, 32767, 32767, 32767, 1);  send_sample(s, 2);
      make_sample(s, -32768, -32768, -32768, -32768, -32768, -32768, 0);
      send_sample(s, 0);
      make_sample(s, 0, 100, -16384, 0, 0, 0, 1);                   send_sample(s, 0);
      make_sample(s, 0, -100, -16384, 0, 0, 0, 0);                  send_sample(s, 1);
      make_sample(s, 0, 0, -16384, 131, -131, 65, 0);               send_sample(s, 0);
      make_sample(s, -16384, 0, 0, -65, 66, -66, 1);                send_sample(s, 0);
      make_sample(s, 16384, 0, 0, 1, -1, 0, 0);                     send_sample(s, 3);
      make_sample(s, 0, 16384, 0, 0, 0, 0, 0);                      send_sample(s, 0);
      make_sample(s, 0, -32768, 0, 0, 0, 0, 1);                     send_sample(s, 0);
      make_sample(s, 32767, -32768, 32767, -32768, 32767, -32768, 0);
      send_sample(s, 0);
      make_sample(s, 0, 0, 0, 32767, -32768, 32767, 1);             send_sample(s, 0);
   endtask

   task automatic test_bias_extremes();
      sample_type s;
      write_bias(icf_pkg::CSR_OFF_X, 25'sh0FFFFFF);
      write_bias(icf_pkg::CSR_OFF_Y, -25'sh1000000);
      write_bias(icf_pkg::CSR_OFF_Z, 25'sh0FFFFFF);
      for (int i = 0; i < 6; i++) begin
         make_sample(s, 0, 0, 16384, 32767, -32768, -32768, i % 2);
         send_sample(s, 0);
      end
      write_bias(icf_pkg::CSR_OFF_X, -25'sh1000000);
      write_bias(icf_pkg::CSR_OFF_Y, 25'sh0FFFFFF);
      write_bias(icf_pkg::CSR_OFF_Z, -25'sh1000000);
      for (int i = 0; i < 6; i++) begin
         make_sample(s, 0, 0, 16384, -32768, 32767, 32767, i % 2);
         send_sample(s, 0);
      end
      // The unused index must leave every bias untouched.
      write_bias(CSR_UNUSED, 25'($urandom));
      s = random_sample();
      send_sample(s, 0);
   endtask

   // The receiver stops for a long stretch while samples keep coming, so the
   // block must fill up and push back on its input.
   task automatic test_backpressure();
      hold_off = 1'b1;
      for (int i = 0; i < 20; i++) begin
         send_sample(level_sample(), 0);
      end
   endtask

   task automatic test_random(int count);
      for (int i = 0; i < count; i++) begin
         if (i % 300 == 150) begin
            write_bias(2'($urandom_range(0, 3)), 25'($urandom));
         end
         if ($urandom_range(0, 4) == 0) begin
            send_sample(random_sample(), random_gap());
         end else begin
            send_sample(level_sample(), random_gap());
         end
      end
   endtask

   // Response ready: random stall bursts, the long hold-off on request, and
   // steady acceptance in the quiet part of the run.
   initial begin
      rsp_bus.ready <= 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_off) begin
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_LEN) @(posedge clock);
            hold_off = 1'b0;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Response checker: every taken response is matched against the oldest prediction.
   always @(posedge clock) begin
      attitude_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         responses_seen++;
         if (pending_attitudes.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_SHOWN) begin
               $display("unexpected response: roll %h pitch %h yaw %h last %b",
                        rsp_bus.roll_angle, rsp_bus.pitch_angle, rsp_bus.yaw_dps,
                        rsp_bus.out_last);
            end
         end else begin
            want = pending_attitudes.pop_front();
            if (rsp_bus.roll_angle !== want.roll || rsp_bus.pitch_angle !== want.pitch ||
                rsp_bus.yaw_dps !== want.yaw || rsp_bus.out_last !== want.last) begin
               mismatches++;
               if (mismatches <= MAX_SHOWN) begin
                  $display("response %0d: expected roll %h pitch %h yaw %h last %b",
                           responses_seen, want.roll, want.pitch, want.yaw, want.last);
                  $display("response %0d:   actual roll %h pitch %h yaw %h last %b",
                           responses_seen, rsp_bus.roll_angle, rsp_bus.pitch_angle,
                           rsp_bus.yaw_dps, rsp_bus.out_last);
               end
            end
         end
      end
   end

   // Watchdog: too long without any handshake on any channel ends the run.
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready) || reset) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG) begin
            $display("timeout with %0d responses outstanding", pending_attitudes.size());
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   initial begin
      reset           <= 1'b1;
      req_bus.valid   <= 1'b0;
      req_bus.accel_x <= '0;
      req_bus.accel_y <= '0;
      req_bus.accel_z <= '0;
      req_bus.gyro_x  <= '0;
      req_bus.gyro_y  <= '0;
      req_bus.gyro_z  <= '0;
      req_bus.in_last <= 1'b0;
      csr_bus.valid   <= 1'b0;
      csr_bus.index   <= '0;
      csr_bus.data    <= '0;
      bias_x = 0; bias_y = 0; bias_z = 0;
      roll_track = 0; pitch_track = 0;
      mismatches = 0; responses_seen = 0; samples_sent = 0; bias_writes = 0;
      idle_cycles = 0;
      quiet = 1'b0;
      hold_off = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_bias_extremes();
      test_backpressure();
      write_bias(icf_pkg::CSR_OFF_X, 25'($urandom));
      write_bias(icf_pkg::CSR_OFF_Y, 25'($urandom));
      write_bias(icf_pkg::CSR_OFF_Z, 25'($urandom));
      test_random(1150);
      // The last stretch runs without random gaps or response stalls; only its bias write idles the requests.
      quiet = 1'b1;
      test_random(200);
      req_bus.valid <= 1'b0;

      wait (pending_attitudes.size() == 0);
      repeat (LATENCY) @(posedge clock);
      $display("%0d samples sent, %0d responses checked, %0d bias writes, %0d mismatches",
               samples_sent, responses_seen, bias_writes, mismatches);
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
